// ----- design/srs_pkg.sv -----
// Shared types, constants and helpers for the substring removal stack.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int PATTERN_MAX_DEF = 8;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int PAT_W       = 64;
    localparam int PIDX_W      = 3;
    localparam int DEPTH_OUT_W = 11;
    localparam int RIDX_W      = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LEN   = 1'b0,
        CFG_PATTERN_BYTES = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Pick pattern byte idx; byte 0 is the first character of the pattern.
    function automatic logic [CHAR_W-1:0] pattern_byte(
        input logic [PAT_W-1:0]  pat,
        input logic [PIDX_W-1:0] idx
    );
        return pat[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/srs_stack_mem.sv -----
// Character stack storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srs_stack_mem #(
    parameter int DEPTH = srs_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [srs_pkg::CHAR_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [srs_pkg::CHAR_W-1:0] rdata
);

    logic [srs_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/srs_ctrl.sv -----
// Sequencer for push, pattern scan, pop and read, with the output register.
`timescale 1ns / 1ps
`default_nettype none

module srs_ctrl #(
    parameter int STACK_DEPTH = srs_pkg::STACK_DEPTH_DEF,
    parameter int PATTERN_MAX = srs_pkg::PATTERN_MAX_DEF,
    parameter int AW          = $clog2(STACK_DEPTH)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic [srs_pkg::CHAR_W-1:0]     char_in,
    input  wire logic [srs_pkg::RIDX_W-1:0]     read_index,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [srs_pkg::DEPTH_OUT_W-1:0]     depth,
    output logic                                removed,
    output logic                                overflow,
    output logic [srs_pkg::CHAR_W-1:0]          read_data,
    // configuration
    input  wire logic [srs_pkg::LEN_W-1:0]      pattern_len,
    input  wire logic [srs_pkg::PAT_W-1:0]      pattern_bytes,
    // stack memory
    output logic                                mem_we,
    output logic [AW-1:0]                       mem_waddr,
    output logic [srs_pkg::CHAR_W-1:0]          mem_wdata,
    output logic                                mem_re,
    output logic [AW-1:0]                       mem_raddr,
    input  wire logic [srs_pkg::CHAR_W-1:0]     mem_rdata
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > srs_pkg::RIDX_W) ? DW : srs_pkg::RIDX_W;
    localparam int LW = srs_pkg::LEN_W;
    localparam int PW = srs_pkg::PIDX_W;

    srs_pkg::state_t state_reg, state_next;

    logic [DW-1:0]              depth_reg, depth_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [AW-1:0]              base_reg, base_next;
    logic [PW-1:0]              cnt_reg, cnt_next;
    logic                       chk_vld_reg, chk_vld_next;
    logic [PW-1:0]              chk_idx_reg, chk_idx_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic                       res_removed_reg, res_removed_next;
    logic                       res_overflow_reg, res_overflow_next;
    logic [srs_pkg::CHAR_W-1:0] res_data_reg, res_data_next;

    logic                          out_valid_reg, out_valid_next;
    logic [srs_pkg::DEPTH_OUT_W-1:0] out_depth_reg, out_depth_next;
    logic                          out_removed_reg, out_removed_next;
    logic                          out_overflow_reg, out_overflow_next;
    logic [srs_pkg::CHAR_W-1:0]    out_data_reg, out_data_next;

    logic          in_fire;
    logic          is_push;
    logic          full;
    logic [LW-1:0] eff_len;
    logic [DW-1:0] depth_inc;
    logic          short_stack;
    logic          last_ok;
    logic          quick_match;
    logic          start_scan;
    logic          in_range;
    logic          issue;
    logic          chk_hit;
    logic          chk_last;
    logic          out_free;

    assign in_fire   = in_valid && !in_stall;
    assign is_push   = (opcode == srs_pkg::OP_PUSH);
    assign full      = (depth_reg == DW'(STACK_DEPTH));
    assign eff_len   = (pattern_len > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : pattern_len;
    assign depth_inc = depth_reg + DW'(1);

    assign short_stack = (eff_len == '0) || (depth_inc < DW'(eff_len));
    // the byte being pushed lands on top, so it checks against the last pattern byte
    assign last_ok     = (char_in == srs_pkg::pattern_byte(pattern_bytes,
                                                           PW'(eff_len - LW'(1))));
    assign quick_match = !full && !short_stack && last_ok && (eff_len == LW'(1));
    assign start_scan  = !full && !short_stack && last_ok && (eff_len != LW'(1));
    assign in_range    = CW'(read_index) < CW'(depth_reg);

    assign issue    = ({1'b0, cnt_reg} < (len_reg - LW'(1)));
    assign chk_hit  = (mem_rdata == srs_pkg::pattern_byte(pattern_bytes, chk_idx_reg));
    assign chk_last = ({1'b0, chk_idx_reg} == (len_reg - LW'(2)));
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!is_push)
                    begin
                        state_next = srs_pkg::ST_RDWAIT;
                    end
                    else if (start_scan)
                    begin
                        state_next = srs_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = srs_pkg::ST_RESP;
                    end
                end
            end
            srs_pkg::ST_RDWAIT:
            begin
                state_next = srs_pkg::ST_RESP;
            end
            srs_pkg::ST_SCAN:
            begin
                if (chk_vld_reg && (!chk_hit || chk_last))
                begin
                    state_next = srs_pkg::ST_RESP;
                end
            end
            srs_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        depth_next        = depth_reg;
        len_next          = len_reg;
        base_next         = base_reg;
        cnt_next          = cnt_reg;
        chk_vld_next      = chk_vld_reg;
        chk_idx_next      = chk_idx_reg;
        rd_ok_next        = rd_ok_reg;
        res_removed_next  = res_removed_reg;
        res_overflow_next = res_overflow_reg;
        res_data_next     = res_data_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_depth_next    = out_depth_reg;
        out_removed_next  = out_removed_reg;
        out_overflow_next = out_overflow_reg;
        out_data_next     = out_data_reg;

        case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    len_next          = eff_len;
                    base_next         = AW'(depth_inc - DW'(eff_len));
                    cnt_next          = '0;
                    chk_vld_next      = 1'b0;
                    rd_ok_next        = in_range;
                    res_removed_next  = is_push && quick_match;
                    res_overflow_next = is_push && full;
                    res_data_next     = '0;
                    if (is_push && !full)
                    begin
                        // a one-byte pattern pops the byte just pushed
                        depth_next = quick_match ? depth_reg : depth_inc;
                    end
                end
            end
            srs_pkg::ST_RDWAIT:
            begin
                res_data_next = rd_ok_reg ? mem_rdata : '0;
            end
            srs_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + PW'(1);
                end
                chk_vld_next = issue;
                chk_idx_next = cnt_reg;
                if (chk_vld_reg && chk_hit && chk_last)
                begin
                    res_removed_next = 1'b1;
                    depth_next       = depth_reg - DW'(len_reg);
                end
            end
            srs_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_depth_next    = srs_pkg::DEPTH_OUT_W'(depth_reg);
                    out_removed_next  = res_removed_reg;
                    out_overflow_next = res_overflow_reg;
                    out_data_next     = res_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != srs_pkg::ST_IDLE);
        mem_we    = in_fire && is_push && !full;
        mem_waddr = AW'(depth_reg);
        mem_wdata = char_in;
        mem_re    = 1'b0;
        mem_raddr = AW'(read_index);
        case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                mem_re = in_fire && !is_push;
            end
            srs_pkg::ST_SCAN:
            begin
                mem_re    = issue;
                mem_raddr = base_reg + AW'(cnt_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign depth     = out_depth_reg;
    assign removed   = out_removed_reg;
    assign overflow  = out_overflow_reg;
    assign read_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srs_pkg::ST_IDLE;
            depth_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg          <= len_next;
        base_reg         <= base_next;
        cnt_reg          <= cnt_next;
        chk_idx_reg      <= chk_idx_next;
        rd_ok_reg        <= rd_ok_next;
        res_removed_reg  <= res_removed_next;
        res_overflow_reg <= res_overflow_next;
        res_data_reg     <= res_data_next;
        out_depth_reg    <= out_depth_next;
        out_removed_reg  <= out_removed_next;
        out_overflow_reg <= out_overflow_next;
        out_data_reg     <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- design/substring_removal_stack.sv -----
// Byte stack that drops every occurrence of a configured pattern as bytes are pushed.
// From accepted beat to loaded result, a push with no scan passes through RESP, a read through RDWAIT
// and RESP, and a push whose byte matches the last of an n-byte pattern, n from 2 to 8, through SCAN
// as memory returns one stack entry per cycle, then RESP; a result held by out_stall delays the load.
// One item at a time: the next beat is taken the cycle after its result loads.
// Reset empties the stack, sets pattern_len to 1 and pattern_bytes to 0; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module substring_removal_stack #(
    parameter int STACK_DEPTH = srs_pkg::STACK_DEPTH_DEF,
    parameter int PATTERN_MAX = srs_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            opcode,
    input  wire logic [srs_pkg::CHAR_W-1:0]      char_in,
    input  wire logic [srs_pkg::RIDX_W-1:0]      read_index,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [srs_pkg::DEPTH_OUT_W-1:0]      depth,
    output logic                                 removed,
    output logic                                 overflow,
    output logic [srs_pkg::CHAR_W-1:0]           read_data
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic [srs_pkg::LEN_W-1:0] pattern_len_reg, pattern_len_next;
    logic [srs_pkg::PAT_W-1:0] pattern_bytes_reg, pattern_bytes_next;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [srs_pkg::CHAR_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [srs_pkg::CHAR_W-1:0] mem_rdata;

    always_comb
    begin
        pattern_len_next   = pattern_len_reg;
        pattern_bytes_next = pattern_bytes_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                srs_pkg::CFG_PATTERN_LEN:
                begin
                    pattern_len_next = cfg_data[srs_pkg::LEN_W-1:0];
                end
                srs_pkg::CFG_PATTERN_BYTES:
                begin
                    pattern_bytes_next = cfg_data[srs_pkg::PAT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= srs_pkg::LEN_W'(1);
            pattern_bytes_reg <= '0;
        end
        else
        begin
            pattern_len_reg   <= pattern_len_next;
            pattern_bytes_reg <= pattern_bytes_next;
        end
    end

    srs_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .PATTERN_MAX (PATTERN_MAX),
        .AW          (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .char_in       (char_in),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .depth         (depth),
        .removed       (removed),
        .overflow      (overflow),
        .read_data     (read_data),
        .pattern_len   (pattern_len_reg),
        .pattern_bytes (pattern_bytes_reg),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    srs_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- test/substring_removal_stack_test.sv -----
// Self-checking testbench for the substring removal stack: directed cases, random traffic.
`timescale 1ns / 1ps

module substring_removal_stack_test;
    import srs_pkg::*;

    localparam int DEPTH_MAX   = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;

    typedef struct packed {
        logic [DEPTH_OUT_W-1:0] depth;
        logic                   removed;
        logic                   overflow;
        logic [CHAR_W-1:0]      read_data;
    } step_result_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = CFG_PATTERN_LEN;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic                   opcode     = OP_PUSH;
    logic [CHAR_W-1:0]      char_in    = '0;
    logic [RIDX_W-1:0]      read_index = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [DEPTH_OUT_W-1:0] depth;
    logic                   removed;
    logic                   overflow;
    logic [CHAR_W-1:0]      read_data;

    // Shadow of the stack and the pattern registers
    logic [CHAR_W-1:0] stack_chars [DEPTH_MAX];
    int                stack_used = 0;
    logic [LEN_W-1:0]  pat_len    = 4'd1;
    logic [PAT_W-1:0]  pat_bytes  = '0;

    step_result_t pending_q[$];
    int           mismatches  = 0;
    int           cycles      = 0;
    int           send_idle_pct = 0;
    int           stall_pct   = 0;
    int           hold_cycles = 0;

    substring_removal_stack dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when hold_cycles is loaded
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic int match_len();
        return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
    endfunction

    function automatic step_result_t apply_item(input opcode_t op, input logic [CHAR_W-1:0] ch,
                                                input logic [RIDX_W-1:0] idx);
        step_result_t r;
        int           n;
        bit           hit;
        r = '0;
        if (op == OP_PUSH)
        begin
            if (stack_used >= DEPTH_MAX)
                r.overflow = 1'b1;
            else
            begin
                stack_chars[stack_used] = ch;
                stack_used++;
                n = match_len();
                hit = (n != 0) && (stack_used >= n);
                for (int i = 0; i < n; i++)
                    if (hit && stack_chars[stack_used - n + i] != pat_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    stack_used -= n;
                    r.removed = 1'b1;
                end
            end
        end
        else if (int'(idx) < stack_used)
            r.read_data = stack_chars[idx];
        r.depth = DEPTH_OUT_W'(stack_used);
        return r;
    endfunction

    // Append one expected result at the tail of the queue
    function automatic void queue_expected(input step_result_t r);
        pending_q = {pending_q, r};
    endfunction

    always @(posedge clk)
    begin : check_results
        step_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: depth %0d removed %0b overflow %0b data %02h",
                             depth, removed, overflow, read_data);
            end
            else
            begin
                want = pending_q.pop_front();
                if (depth !== want.depth || removed !== want.removed ||
                    overflow !== want.overflow || read_data !== want.read_data)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: depth %0d/%0d removed %0b/%0b overflow %0b/%0b %s",
                                 want.depth, depth, want.removed, removed, want.overflow,
                                 overflow, $sformatf("data %02h/%02h (expected/actual)",
                                 want.read_data, read_data));
                end
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [CHAR_W-1:0] ch,
                             input logic [RIDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        char_in    <= ch;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_expected(apply_item(op, ch, idx));
    endtask

    task automatic send_push(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUSH, ch, RIDX_W'($urandom_range(1023)));
    endtask

    task automatic send_read(input int idx);
        send_item(OP_READ, CHAR_W'($urandom_range(255)), RIDX_W'(idx));
    endtask

    // Drop valid and wait until every result is back and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_pattern(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] bytes);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PATTERN_LEN;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_index <= CFG_PATTERN_BYTES;
        cfg_data  <= bytes;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pat_len   = len;
        pat_bytes = bytes;
    endtask

    // Mostly whole or partial patterns, with stray bytes and reads mixed in
    task automatic push_random_items(input int count);
        int done;
        int n;
        int r;
        int k;
        done = 0;
        while (done < count)
        begin
            n = match_len();
            r = $urandom_range(99);
            if (r < 30 && n > 0)
            begin
                for (int i = 0; i < n; i++)
                    send_push(pat_bytes[8*i +: 8]);
                done += n;
            end
            else if (r < 50 && n > 1)
            begin
                k = $urandom_range(n - 1, 1);
                for (int i = 0; i < k; i++)
                    send_push(pat_bytes[8*i +: 8]);
                done += k;
            end
            else if (r < 68 && n > 0)
            begin
                k = $urandom_range(n - 1);
                send_push(pat_bytes[8*k +: 8]);
                done++;
            end
            else if (r < 84)
            begin
                send_push(CHAR_W'($urandom_range(255)));
                done++;
            end
            else
            begin
                if ($urandom_range(3) != 0)
                    send_read($urandom_range((stack_used > 1023) ? 1023 : stack_used));
                else
                    send_read($urandom_range(1023));
                done++;
            end
        end
    endtask

    task automatic test_defaults();
        // reset pattern is one zero byte, so a zero push pops straight away
        send_push(8'h00);
        send_push(8'hFF);
        send_read(0);
        send_read(1);
        send_read(1023);
    endtask

    task automatic test_pattern_length_extremes();
        write_pattern(4'd0, '1);
        send_push(8'hFF);
        send_push(8'h00);
        // length above the maximum saturates to eight bytes
        write_pattern(4'd15, 64'h01FE_7F80_00FF_55AA);
        for (int i = 0; i < PATTERN_MAX_DEF; i++)
            send_push(pat_bytes[8*i +: 8]);
    endtask

    task automatic test_nested_removal();
        // "a" then "ab" pops, exposing the first "a" which completes with the last "b"
        write_pattern(4'd2, 64'h6261);
        send_push(8'h61);
        send_push(8'h61);
        send_push(8'h62);
        send_push(8'h62);
        send_read(2);
        send_read(3);
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 0;
        stall_pct = 0;
        write_pattern(4'd1, {$urandom, $urandom});
        push_random_items(125);
        send_idle_pct = 68;
        write_pattern(4'd8, {$urandom, $urandom});
        push_random_items(125);
        send_idle_pct = 0;
        stall_pct = 68;
        write_pattern(LEN_W'($urandom_range(7, 2)), {$urandom, $urandom});
        push_random_items(125);
        send_idle_pct = 30;
        stall_pct = 30;
        write_pattern(4'd3, {$urandom, $urandom});
        push_random_items(125);
    endtask

    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        push_random_items(30);
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_pattern_length_extremes();
        test_nested_removal();
        test_random_traffic();
        test_backpressure();
        settle();
        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
